/* src/ps2mt_pkg.sv */
// Package: shared constants and types for the PS/2 mouse packet tracker.
`default_nettype none

package ps2mt_pkg;

  // Coordinate width default and configuration register format
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CFG_BITS       = 12;
  localparam int unsigned CFG_IDX_BITS   = 2;

  localparam logic [CFG_BITS-1:0] MAX_X_RST = 12'd299;
  localparam logic [CFG_BITS-1:0] MAX_Y_RST = 12'd179;

  // Byte positions inside a packet
  localparam logic [1:0] IDX_HEADER = 2'd0;
  localparam logic [1:0] IDX_X      = 2'd1;
  localparam logic [1:0] IDX_Y      = 2'd2;

  // Header bit positions
  localparam int unsigned HDR_SIGN_X = 4;
  localparam int unsigned HDR_SIGN_Y = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_X = 2'd0,
    CFG_MAX_Y = 2'd1
  } cfg_reg_e;

  // A complete three-byte packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } pkt_t;

endpackage

`default_nettype wire

/* src/ps2mt_in_if.sv */
// Interface: input byte channel (valid/ready with aux flag and data byte).
`default_nettype none

interface ps2mt_in_if;
  logic       valid;
  logic       ready;
  logic       aux_flag;
  logic [7:0] data_byte;

  modport source (output valid, output aux_flag, output data_byte, input ready);
  modport sink   (input valid, input aux_flag, input data_byte, output ready);
endinterface

`default_nettype wire

/* src/ps2mt_out_if.sv */
// Interface: result channel (valid/ready with cursor, deltas and button masks).
`default_nettype none

interface ps2mt_out_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic signed [8:0]     delta_x;
  logic signed [8:0]     delta_y;
  logic                  moved;
  logic [2:0]            pressed_mask;
  logic [2:0]            released_mask;

  modport source (
    output valid, output cursor_x, output cursor_y, output delta_x, output delta_y,
    output moved, output pressed_mask, output released_mask, input ready
  );
  modport sink (
    input valid, input cursor_x, input cursor_y, input delta_x, input delta_y,
    input moved, input pressed_mask, input released_mask, output ready
  );
endinterface

`default_nettype wire

/* src/ps2mt_assembler.sv */
// Packet assembler: groups flagged bytes into header/X/Y packets by position.
`default_nettype none

module ps2mt_assembler
  import ps2mt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,     // a flagged byte is consumed
  input  wire logic [7:0] byte_i,
  output      logic       last_o,     // next flagged byte completes a packet
  output      pkt_t       pkt_o
);

  logic [1:0] idx_q, idx_d;
  logic [7:0] header_q, header_d;
  logic [7:0] x_byte_q, x_byte_d;

  // Index value 3 cannot occur but completes a packet like index 2
  assign last_o = idx_q[1];

  always_comb begin
    idx_d    = idx_q;
    header_d = header_q;
    x_byte_d = x_byte_q;
    if (step_i) begin
      case (idx_q)
        IDX_HEADER: begin
          header_d = byte_i;
          idx_d    = IDX_X;
        end
        IDX_X: begin
          x_byte_d = byte_i;
          idx_d    = IDX_Y;
        end
        default: begin
          idx_d = IDX_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= IDX_HEADER;
      header_q <= '0;
      x_byte_q <= '0;
    end else begin
      idx_q    <= idx_d;
      header_q <= header_d;
      x_byte_q <= x_byte_d;
    end
  end

  assign pkt_o.header = header_q;
  assign pkt_o.x_byte = x_byte_q;
  assign pkt_o.y_byte = byte_i;

endmodule

`default_nettype wire

/* src/ps2mt_tracker.sv */
// Cursor tracker: applies packet deltas with clamping and derives button edges.
`default_nettype none

module ps2mt_tracker
  import ps2mt_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  update_i,
  input  wire pkt_t                  pkt_i,
  input  wire logic [CFG_BITS-1:0]   max_x_i,
  input  wire logic [CFG_BITS-1:0]   max_y_i,
  output      logic [COORD_BITS-1:0] cursor_x_o,
  output      logic [COORD_BITS-1:0] cursor_y_o,
  output      logic signed [8:0]     delta_x_o,
  output      logic signed [8:0]     delta_y_o,
  output      logic                  moved_o,
  output      logic [2:0]            pressed_o,
  output      logic [2:0]            released_o
);

  localparam int unsigned SW = COORD_BITS + 2;  // signed sum width
  localparam int unsigned LW = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam logic [LW-1:0] COORD_MASK = LW'({COORD_BITS{1'b1}});

  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic [2:0]            btn_q;

  logic [8:0]            dx, dy;
  logic [SW-1:0]         sum_x, sum_y;
  logic [LW-1:0]         max_x_w, max_y_w;
  logic [COORD_BITS-1:0] lim_x, lim_y;

  // 9-bit deltas from header sign bits
  assign moved_o = (pkt_i.x_byte != 8'd0) || (pkt_i.y_byte != 8'd0);
  assign dx      = {pkt_i.header[HDR_SIGN_X], pkt_i.x_byte};
  assign dy      = {pkt_i.header[HDR_SIGN_Y], pkt_i.y_byte};

  // Candidate positions: x adds, y subtracts (up is positive)
  assign sum_x = {2'b00, pos_x_q} + {{(SW-9){dx[8]}}, dx};
  assign sum_y = {2'b00, pos_y_q} - {{(SW-9){dy[8]}}, dy};

  // Clamp limits, bounded by the coordinate width
  assign max_x_w = LW'(max_x_i);
  assign max_y_w = LW'(max_y_i);
  assign lim_x   = (max_x_w > COORD_MASK) ? COORD_MASK[COORD_BITS-1:0]
                                          : max_x_w[COORD_BITS-1:0];
  assign lim_y   = (max_y_w > COORD_MASK) ? COORD_MASK[COORD_BITS-1:0]
                                          : max_y_w[COORD_BITS-1:0];

  // Clamp to 0..limit
  always_comb begin
    if (sum_x[SW-1] || (sum_x == '0)) begin
      pos_x_d = '0;
    end else if (sum_x[COORD_BITS:0] >= {1'b0, lim_x}) begin
      pos_x_d = lim_x;
    end else begin
      pos_x_d = sum_x[COORD_BITS-1:0];
    end
    if (sum_y[SW-1] || (sum_y == '0)) begin
      pos_y_d = '0;
    end else if (sum_y[COORD_BITS:0] >= {1'b0, lim_y}) begin
      pos_y_d = lim_y;
    end else begin
      pos_y_d = sum_y[COORD_BITS-1:0];
    end
  end

  // Result fields for this packet
  assign cursor_x_o = moved_o ? pos_x_d : pos_x_q;
  assign cursor_y_o = moved_o ? pos_y_d : pos_y_q;
  assign delta_x_o  = moved_o ? $signed(dx) : 9'sd0;
  assign delta_y_o  = moved_o ? $signed(dy) : 9'sd0;
  assign pressed_o  = pkt_i.header[2:0] & ~btn_q;
  assign released_o = btn_q & ~pkt_i.header[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      btn_q   <= '0;
    end else if (update_i) begin
      pos_x_q <= cursor_x_o;
      pos_y_q <= cursor_y_o;
      btn_q   <= pkt_i.header[2:0];
    end
  end

endmodule

`default_nettype wire

/* src/ps2_mouse_packet_tracker.sv */
// Top level: PS/2 mouse packet tracker with input register and result register.
//
//  channel   dir  transaction                               fields
//  in_ch     in   one controller byte                       aux_flag, data_byte
//  out_ch    out  one result per completed 3-byte packet    cursor_x/y, delta_x/y,
//                                                           moved, pressed/released
//  cfg       in   register write (0 max_x, 1 max_y)         cfg_we_i, cfg_idx_i, cfg_data_i
//
//  One byte per cycle while no packet's last byte is held back. A byte is captured in the
//  input register and processed from there; a packet's result is registered in the output register.
//  Unflagged bytes and packet-header/X bytes never wait on out_ch; a packet's last
//  byte waits only while the output register holds an untaken result.
//  Reset clears the packet position, buttons and cursor; max_x/max_y reset to 299/179.
`default_nettype none

module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  ps2mt_in_if.sink                     in_ch,
  ps2mt_out_if.source                  out_ch,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]     cfg_data_i
);

  logic                s1_valid_q;
  logic                s1_aux_q;
  logic [7:0]          s1_byte_q;
  logic [CFG_BITS-1:0] max_x_q, max_y_q;

  logic                last;
  pkt_t                pkt;
  logic                makes_result, out_free, s1_adv, step, emit;

  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [8:0]     dx, dy;
  logic                  moved;
  logic [2:0]            pressed, released;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= MAX_X_RST;
      max_y_q <= MAX_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_MAX_X: max_x_q <= cfg_data_i;
        CFG_MAX_Y: max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flow control between input register and output register
  assign makes_result = s1_aux_q && last;
  assign out_free     = !out_ch.valid || out_ch.ready;
  assign s1_adv       = s1_valid_q && (!makes_result || out_free);
  assign step         = s1_adv && s1_aux_q;
  assign emit         = s1_adv && makes_result;
  assign in_ch.ready  = !s1_valid_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_aux_q  <= in_ch.aux_flag;
      s1_byte_q <= in_ch.data_byte;
    end
  end

  ps2mt_assembler u_asm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .last_o (last),
    .pkt_o  (pkt)
  );

  ps2mt_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_trk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (emit),
    .pkt_i      (pkt),
    .max_x_i    (max_x_q),
    .max_y_i    (max_y_q),
    .cursor_x_o (cur_x),
    .cursor_y_o (cur_y),
    .delta_x_o  (dx),
    .delta_y_o  (dy),
    .moved_o    (moved),
    .pressed_o  (pressed),
    .released_o (released)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ch.cursor_x      <= cur_x;
      out_ch.cursor_y      <= cur_y;
      out_ch.delta_x       <= dx;
      out_ch.delta_y       <= dy;
      out_ch.moved         <= moved;
      out_ch.pressed_mask  <= pressed;
      out_ch.released_mask <= released;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_ps2_mouse_packet_tracker.sv */
// Testbench for the PS/2 mouse packet tracker: directed table, random packets, live scoreboard.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_tracker;
  import ps2mt_pkg::*;

  localparam int CW              = COORD_BITS_DEF;
  localparam int CLK_PERIOD      = 10;
  localparam int DIR_ROWS        = 24;
  localparam int RAND_PHASES     = 6;
  localparam int BYTES_PER_PHASE = 85;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 3000;

  // Indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // One packet report, in port order
  typedef struct packed {
    logic [CW-1:0]     cursor_x;
    logic [CW-1:0]     cursor_y;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y;
    logic              moved;
    logic [2:0]        pressed;
    logic [2:0]        released;
  } report_t;

  // Directed row: byte, plus a hand-written report when lit is set
  typedef struct packed {
    logic    aux;
    logic [7:0] data;
    logic    lit;
    report_t want;
  } stim_row_t;

  localparam report_t NO_RPT = '0;

  // Starts from reset: cursor 0,0, buttons up, limits 299/179
  localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
    {1'b0, 8'hFF, 1'b0, NO_RPT},
    // signs set, both deltas zero: no move, all buttons go down
    {1'b1, 8'h37, 1'b0, NO_RPT},
    {1'b1, 8'h00, 1'b0, NO_RPT},
    {1'b1, 8'h00, 1'b1, 12'd0, 12'd0, 9'sd0, 9'sd0, 1'b0, 3'd7, 3'd0},
    // largest positive x, buttons released
    {1'b1, 8'h08, 1'b0, NO_RPT},
    {1'b1, 8'hFF, 1'b0, NO_RPT},
    {1'b1, 8'h00, 1'b1, 12'd255, 12'd0, 9'sd255, 9'sd0, 1'b1, 3'd0, 3'd7},
    // x byte zero with sign set gives -256, clamps at zero
    {1'b1, 8'h10, 1'b0, NO_RPT},
    {1'b1, 8'h00, 1'b0, NO_RPT},
    {1'b1, 8'h01, 1'b1, 12'd0, 12'd0, 9'h100, 9'sd1, 1'b1, 3'd0, 3'd0},
    // y of -256 pushes the cursor down past max_y
    {1'b1, 8'h20, 1'b0, NO_RPT},
    {1'b1, 8'h7F, 1'b0, NO_RPT},
    {1'b1, 8'h00, 1'b1, 12'd127, 12'd179, 9'sd127, 9'h100, 1'b1, 3'd0, 3'd0},
    // unflagged bytes inside a packet are skipped
    {1'b1, 8'h01, 1'b0, NO_RPT},
    {1'b0, 8'h55, 1'b0, NO_RPT},
    {1'b1, 8'h80, 1'b0, NO_RPT},
    {1'b0, 8'hAA, 1'b0, NO_RPT},
    {1'b1, 8'hFF, 1'b1, 12'd255, 12'd0, 9'sd128, 9'sd255, 1'b1, 3'd1, 3'd0},
    // x clamps at max_x, left to right button swap
    {1'b1, 8'h02, 1'b0, NO_RPT},
    {1'b1, 8'hFF, 1'b0, NO_RPT},
    {1'b1, 8'h80, 1'b1, 12'd299, 12'd0, 9'sd255, 9'sd128, 1'b1, 3'd2, 3'd1},
    // both signs, deltas of -255 from low bytes of 1: left to the predictor
    {1'b1, 8'h34, 1'b0, NO_RPT},
    {1'b1, 8'h01, 1'b0, NO_RPT},
    {1'b1, 8'h01, 1'b0, NO_RPT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0]     cfg_data_i;

  ps2mt_in_if                               in_ch ();
  ps2mt_out_if #(.COORD_BITS(COORD_BITS_DEF)) out_ch ();

  ps2_mouse_packet_tracker #(.COORD_BITS(COORD_BITS_DEF)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Tracker state mirrored by the predictor
  logic [1:0]      pkt_pos;
  logic [7:0]      hdr_q;
  logic [7:0]      xb_q;
  logic [2:0]      btn_q;
  logic [CW-1:0]   cur_x;
  logic [CW-1:0]   cur_y;
  logic [CFG_BITS-1:0] lim_x;
  logic [CFG_BITS-1:0] lim_y;

  report_t pending_reports[$];
  int      send_gap_pct;
  int      recv_gap_pct;
  bit      hold_req;
  int      mismatch_cnt;
  int      bytes_taken;
  int      bytes_ignored;
  int      reports_seen;
  int      moves_seen;
  int      settings_used;
  int      quiet_cycles;

  function automatic logic [CW-1:0] clamp_coord(input int v, input logic [CFG_BITS-1:0] lim);
    if (v <= 0) return '0;
    if (v >= int'(lim)) return lim[CW-1:0];
    return CW'(v);
  endfunction

  // Advance the mirrored tracker by one byte; returns 1 when a packet completes
  function automatic bit track_mouse_byte(input logic aux, input logic [7:0] b,
                                          output report_t rpt);
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [2:0]        nb;
    rpt = '0;
    if (!aux) return 1'b0;
    case (pkt_pos)
      IDX_HEADER: begin
        hdr_q   = b;
        pkt_pos = IDX_X;
        return 1'b0;
      end
      IDX_X: begin
        xb_q    = b;
        pkt_pos = IDX_Y;
        return 1'b0;
      end
      default: ;
    endcase
    pkt_pos = IDX_HEADER;
    if (xb_q != 8'h00 || b != 8'h00) begin
      dx    = {hdr_q[HDR_SIGN_X], xb_q};
      dy    = {hdr_q[HDR_SIGN_Y], b};
      cur_x = clamp_coord(int'(cur_x) + int'(dx), lim_x);
      cur_y = clamp_coord(int'(cur_y) - int'(dy), lim_y);
      rpt.delta_x = dx;
      rpt.delta_y = dy;
      rpt.moved   = 1'b1;
    end
    nb           = hdr_q[2:0];
    rpt.pressed  = nb & ~btn_q;
    rpt.released = btn_q & ~nb;
    btn_q        = nb;
    rpt.cursor_x = cur_x;
    rpt.cursor_y = cur_y;
    return 1'b1;
  endfunction

  // Biased byte: zero and the edges of the delta range come up often
  function automatic logic [7:0] mouse_byte_rand();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte, wait for the transaction, queue the report it causes
  task automatic offer_byte(input logic aux, input logic [7:0] b,
                            input logic use_lit, input report_t lit_rpt);
    report_t rpt;
    bit      done;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.aux_flag  <= aux;
    in_ch.data_byte <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    done = track_mouse_byte(aux, b, rpt);
    if (done) pending_reports.push_back(use_lit ? lit_rpt : rpt);
    bytes_taken++;
    if (!aux) bytes_ignored++;
    @(negedge clk_i);
  endtask

  // Drain the tracker, then load new cursor limits
  task automatic program_limits(input logic [CFG_BITS-1:0] mx, input logic [CFG_BITS-1:0] my,
                                input bit poke_spare);
    logic [CFG_IDX_BITS-1:0] idx [4];
    logic [CFG_BITS-1:0]     val [4];
    int                      n;
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    idx[0] = CFG_MAX_X;        val[0] = mx;
    idx[1] = CFG_MAX_Y;        val[1] = my;
    idx[2] = CFG_IDX_SPARE_LO; val[2] = CFG_BITS'($urandom);
    idx[3] = CFG_IDX_SPARE_HI; val[3] = CFG_BITS'($urandom);
    n = poke_spare ? 4 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      case (idx[i])
        CFG_MAX_X: lim_x = val[i];
        CFG_MAX_Y: lim_y = val[i];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic compare_field(input string fname, input integer exp_v, input integer act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Receiver: random ready, or a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Scoreboard: each report against the oldest prediction
  always @(posedge clk_i) begin : report_check
    report_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with none pending, actual x=%0d y=%0d", $time,
                 out_ch.cursor_x, out_ch.cursor_y);
        mismatch_cnt++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("cursor_x", want.cursor_x, out_ch.cursor_x);
        compare_field("cursor_y", want.cursor_y, out_ch.cursor_y);
        compare_field("delta_x", want.delta_x, out_ch.delta_x);
        compare_field("delta_y", want.delta_y, out_ch.delta_y);
        compare_field("moved", want.moved, out_ch.moved);
        compare_field("pressed_mask", want.pressed, out_ch.pressed_mask);
        compare_field("released_mask", want.released, out_ch.released_mask);
        reports_seen++;
        if (want.moved) moves_seen++;
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d reports pending", $time, quiet_cycles,
               pending_reports.size());
      $display("tb_ps2_mouse_packet_tracker failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [CFG_BITS-1:0] phase_mx [RAND_PHASES];
    logic [CFG_BITS-1:0] phase_my [RAND_PHASES];
    int                  flagged;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.aux_flag  = 1'b0;
    in_ch.data_byte = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MAX_X;
    cfg_data_i      = '0;
    hold_req        = 1'b0;
    mismatch_cnt    = 0;
    bytes_taken     = 0;
    bytes_ignored   = 0;
    reports_seen    = 0;
    moves_seen      = 0;
    settings_used   = 1;
    pkt_pos = IDX_HEADER;
    hdr_q   = '0;
    xb_q    = '0;
    btn_q   = '0;
    cur_x   = '0;
    cur_y   = '0;
    lim_x   = MAX_X_RST;
    lim_y   = MAX_Y_RST;
    send_gap_pct = 7;
    recv_gap_pct = 46;

    phase_mx[0] = 12'd4095;                 phase_my[0] = 12'd4095;
    phase_mx[1] = 12'd0;                    phase_my[1] = 12'd0;
    phase_mx[2] = 12'($urandom_range(4095)); phase_my[2] = 12'($urandom_range(4095));
    phase_mx[3] = 12'd4095;                 phase_my[3] = 12'd0;
    phase_mx[4] = 12'd0;                    phase_my[4] = 12'd4095;
    phase_mx[5] = 12'($urandom_range(40, 1)); phase_my[5] = 12'($urandom_range(40, 1));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table at reset limits
    for (int r = 0; r < DIR_ROWS; r++)
      offer_byte(DIR_TBL[r].aux, DIR_TBL[r].data, DIR_TBL[r].lit, DIR_TBL[r].want);

    // Random packets; idle mix changes every two phases
    for (int p = 0; p < RAND_PHASES; p++) begin
      program_limits(phase_mx[p], phase_my[p], p == 0);
      case (p / 2)
        0: begin send_gap_pct = 7;  recv_gap_pct = 46; end
        1: begin send_gap_pct = 46; recv_gap_pct = 7;  end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      // Back up the result path while bytes keep coming
      if (p == 4) hold_req = 1'b1;
      flagged = 0;
      while (flagged < BYTES_PER_PHASE) begin
        if ($urandom_range(99) < 15) begin
          offer_byte(1'b0, 8'($urandom), 1'b0, NO_RPT);
        end else begin
          offer_byte(1'b1, mouse_byte_rand(), 1'b0, NO_RPT);
          flagged++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Run covered %0d bytes (%0d unflagged) under %0d limit settings,", bytes_taken,
             bytes_ignored, settings_used);
    $display("checking %0d packet reports, %0d of them with cursor movement.", reports_seen,
             moves_seen);
    if (mismatch_cnt == 0) begin
      $display("tb_ps2_mouse_packet_tracker passed");
    end else begin
      $display("tb_ps2_mouse_packet_tracker failed");
    end
    $finish;
  end

endmodule
